[rtl/core/two_rotor_substitution_cipher_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-rotor substitution cipher
// Concurrent checks; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_ROTOR_SUBSTITUTION_CIPHER_ASSERT_SVH
`define TWO_ROTOR_SUBSTITUTION_CIPHER_ASSERT_SVH

`ifndef SYNTH
`define TRSC_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("cipher check failed");
`define TRSC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("cipher check failed");
`else
`define TRSC_ASSERT_IMPLY(label, clk, rst, a, b)
`define TRSC_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

[rtl/core/trsc_pkg.sv]
// ----------------------------------------------------------------------------
// trsc_pkg
// Types, constants and modulo helpers shared by the cipher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trsc_pkg;

  localparam int ALPHA_SIZE = 26;
  localparam int LW         = 5;

  typedef logic [LW-1:0] letter_t;

  localparam letter_t LETTER_MAX = LW'(ALPHA_SIZE - 1);
  localparam logic [7:0] CHAR_A  = 8'h61;
  localparam logic [7:0] CHAR_Z  = 8'h7a;

  typedef enum logic [1:0] {
    FUNC_ENC  = 2'd0,
    FUNC_DEC  = 2'd1,
    FUNC_FAST = 2'd2,
    FUNC_SLOW = 2'd3
  } func_t;

  typedef struct packed {
    logic    en;
    letter_t index;
    letter_t value;
  } ring_wr_t;

  typedef struct packed {
    letter_t fast;
    letter_t slow;
  } pos_t;

  function automatic letter_t mod_add(letter_t a, letter_t b);
    logic [LW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LW+1)'(ALPHA_SIZE)) begin
      s = s - (LW+1)'(ALPHA_SIZE);
    end
    return s[LW-1:0];
  endfunction

  function automatic letter_t mod_sub(letter_t a, letter_t b);
    logic [LW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (LW+1)'(ALPHA_SIZE) - {1'b0, b};
    end
    return s[LW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/trsc_rotor.sv]
// ----------------------------------------------------------------------------
// trsc_rotor
// Ring table and its inverse for one rotor; one write, two lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trsc_rotor (
  input  wire                 clk,
  input  trsc_pkg::ring_wr_t  wr,
  input  trsc_pkg::letter_t   ring_addr,
  output trsc_pkg::letter_t   ring_data,
  input  trsc_pkg::letter_t   inv_addr,
  output trsc_pkg::letter_t   inv_data
);
  import trsc_pkg::*;

  letter_t ring [ALPHA_SIZE];
  letter_t inv  [ALPHA_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ring[wr.index] <= wr.value;
      inv[wr.value]  <= wr.index;
    end
  end

  assign ring_data = ring[ring_addr];
  assign inv_data  = inv[inv_addr];

endmodule

`default_nettype wire

[rtl/core/trsc_position.sv]
// ----------------------------------------------------------------------------
// trsc_position
// Fast and slow rotor position counters with restart and carry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trsc_position (
  input  wire              clk,
  input  wire              rst,
  input  wire              restart,
  input  wire              fire,
  input  wire              advance,
  output trsc_pkg::pos_t   eff
);
  import trsc_pkg::*;

  pos_t pos;
  pos_t pos_next;

  // positions seen by the current request, restart applied first
  assign eff = restart ? '0 : pos;

  always_comb begin
    pos_next = eff;
    if (advance) begin
      if (eff.fast == LETTER_MAX) begin
        pos_next.fast = '0;
        pos_next.slow = mod_add(eff.slow, LW'(1));
      end else begin
        pos_next.fast = eff.fast + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (fire) begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/two_rotor_substitution_cipher.sv]
// A request is captured in the input register and moves to the output register
// when the output is not stalled. Throughput: one request per cycle while not stalled.
// Ring writes retire in the cycle after acceptance and give no result.
// The path is input register, two table lookups with mod-26 adds or subtracts, result reg.
// Reset clears both valids and both rotor positions; ring tables are
// undefined until loaded.
// ----------------------------------------------------------------------------
// two_rotor_substitution_cipher
// Two-rotor letter cipher, one byte per cycle while the output is not stalled, with in-band ring loading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_rotor_substitution_cipher (
  input  wire        clk,
  input  wire        rst,
  input  wire        req_valid,
  output logic       req_stall,
  input  wire  [1:0] func,
  input  wire  [7:0] char_in,
  input  wire  [4:0] entry_index,
  input  wire  [4:0] entry_value,
  input  wire        restart,
  output logic       res_valid,
  input  wire        res_stall,
  output logic [7:0] char_out
);
  import trsc_pkg::*;
  `include "two_rotor_substitution_cipher_assert.svh"

  logic       s1_valid;
  func_t      s1_func;
  logic [7:0] s1_char;
  letter_t    s1_index;
  letter_t    s1_value;
  logic       s1_restart;

  logic       s1_write;
  logic       s1_letter;
  logic       s1_fire;
  logic       req_accept;
  logic       in_range;
  logic [7:0] char_off;
  letter_t    p;
  pos_t       eff;

  ring_wr_t   fast_wr;
  ring_wr_t   slow_wr;
  letter_t    fast_ring_addr;
  letter_t    fast_ring_data;
  letter_t    fast_inv_addr;
  letter_t    fast_inv_data;
  letter_t    slow_ring_addr;
  letter_t    slow_ring_data;
  letter_t    slow_inv_data;
  letter_t    r;
  logic [7:0] result;

  assign s1_write  = (s1_func == FUNC_FAST) || (s1_func == FUNC_SLOW);
  assign s1_letter = (s1_char >= CHAR_A) && (s1_char <= CHAR_Z);
  assign s1_fire   = s1_valid && (s1_write || !res_valid || !res_stall);
  assign req_stall = s1_valid && !s1_fire;
  assign req_accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_func    <= func_t'(func);
      s1_char    <= char_in;
      s1_index   <= entry_index;
      s1_value   <= entry_value;
      s1_restart <= restart;
    end
  end

  trsc_position u_position (
    .clk     (clk),
    .rst     (rst),
    .restart (s1_valid && s1_restart),
    .fire    (s1_fire),
    .advance (!s1_write && s1_letter),
    .eff     (eff)
  );

  assign in_range = (s1_index <= LETTER_MAX) && (s1_value <= LETTER_MAX);

  always_comb begin
    fast_wr.en    = s1_fire && in_range && (s1_func == FUNC_FAST);
    fast_wr.index = s1_index;
    fast_wr.value = s1_value;
    slow_wr.en    = s1_fire && in_range && (s1_func == FUNC_SLOW);
    slow_wr.index = s1_index;
    slow_wr.value = s1_value;
  end

  assign char_off = s1_char - CHAR_A;
  assign p        = char_off[LW-1:0];

  assign fast_ring_addr = mod_add(p, eff.fast);
  assign slow_ring_addr = mod_add(fast_ring_data, eff.slow);
  assign fast_inv_addr  = mod_sub(slow_inv_data, eff.slow);

  trsc_rotor u_fast (
    .clk       (clk),
    .wr        (fast_wr),
    .ring_addr (fast_ring_addr),
    .ring_data (fast_ring_data),
    .inv_addr  (fast_inv_addr),
    .inv_data  (fast_inv_data)
  );

  trsc_rotor u_slow (
    .clk       (clk),
    .wr        (slow_wr),
    .ring_addr (slow_ring_addr),
    .ring_data (slow_ring_data),
    .inv_addr  (p),
    .inv_data  (slow_inv_data)
  );

  always_comb begin
    if (s1_func == FUNC_DEC) begin
      r = mod_sub(fast_inv_data, eff.fast);
    end else begin
      r = slow_ring_data;
    end
    result = s1_letter ? (CHAR_A + {3'b000, r}) : s1_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && !s1_write) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !s1_write) begin
      char_out <= result;
    end
  end

  `TRSC_ASSERT_IMPLY(a_stall_only_busy, clk, rst, req_stall, s1_valid && !s1_write)
  `TRSC_ASSERT_NEXT(a_cipher_gives_result, clk, rst, s1_fire && !s1_write, res_valid)
  `TRSC_ASSERT_IMPLY(a_fast_in_range, clk, rst, 1'b1, eff.fast <= LETTER_MAX)
  `TRSC_ASSERT_NEXT(a_fast_wraps, clk, rst,
    s1_fire && !s1_write && s1_letter && (eff.fast == LETTER_MAX),
    u_position.pos.fast == '0)

endmodule

`default_nettype wire
